### rtl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_HEIGHT_DEF   = 1024;
   localparam int WORD_BITS        = 32;
   localparam int PIX_BITS         = 24;
   localparam int DIM_BITS         = 11;
   localparam int COL_SUM_BITS     = 10;
   localparam int WIN_SUM_BITS     = 12;
   localparam int FRAME_WIDTH_RST  = 800;
   localparam int FRAME_HEIGHT_RST = 600;
   localparam logic [7:0]  ALPHA   = 8'hFF;
   // ceil(2^16 / 9), exact for sums below 2304
   localparam logic [12:0] RECIP9  = 13'd7282;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic c0;
      logic emit;
      logic last;
      logic up_en;
      logic mid_en;
   } ctl_type;

   function automatic logic [7:0] div9(input logic [WIN_SUM_BITS-1:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(RECIP9);
      return p[23:16];
   endfunction

endpackage

`default_nettype wire

### rtl/bb3_if.sv
`default_nettype none

interface bb3_req_if;
   logic                          valid;
   logic                          ready;
   logic [bb3_pkg::WORD_BITS-1:0] pixel_word;
   logic                          drain;

   modport source (output valid, output pixel_word, output drain, input ready);
   modport sink   (input valid, input pixel_word, input drain, output ready);
endinterface

interface bb3_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bb3_pkg::WORD_BITS-1:0] blurred_word;
   logic                          last_of_frame;

   modport source (output valid, output blurred_word, output last_of_frame, input ready);
   modport sink   (input valid, input blurred_word, input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/box_blur_3x3_rgb.sv
// 3x3 box blur over a raster-order RGBA8888 pixel stream.
// req_if carries one request per pixel (pixel_word, alpha ignored) or a drain
// request that stands for a zero pixel; rsp_if carries the averaged pixel with
// alpha 0xFF and last_of_frame on the bottom-right pixel. Both are valid/ready.
// The result for pixel (r, c) is produced by the request one line plus one
// pixel later, so frame_width+1 drain requests after a frame flush its last row.
// A result reaches rsp_if through stage 1 (line store read), the sum stage (window
// and column sums) and the divide by 9 into the output register.
// Throughput: one request per cycle while rsp_if does not stall, set by the single
// read and write port of each line store, used once per request.
// The APB-style port holds frame_width (offset 0) and frame_height (offset 4);
// values are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT; write only while idle.
// Reset: counters and window clear, registers go to 800 x 600, and both line
// stores are zeroed by a pass over all MAX_WIDTH addresses during which req_if.ready is low.
// When rsp_if stalls, the output register holds, one more result waits in the
// sum stage, and requests are taken until a result has nowhere to go.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bb3_req_if.sink          req_if,
   bb3_rsp_if.source        rsp_if,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int DB = bb3_pkg::DIM_BITS;
   localparam int CB = bb3_pkg::COL_SUM_BITS;
   localparam int SB = bb3_pkg::WIN_SUM_BITS;
   localparam int PB = bb3_pkg::PIX_BITS;
   localparam logic [12:0] W_HI = 13'(MAX_WIDTH);
   localparam logic [12:0] H_HI = 13'(MAX_HEIGHT);
   localparam logic [DB-1:0] W_RST = DB'((bb3_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                                         MAX_WIDTH : bb3_pkg::FRAME_WIDTH_RST);
   localparam logic [DB-1:0] H_RST = DB'((bb3_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                                         MAX_HEIGHT : bb3_pkg::FRAME_HEIGHT_RST);

   // configuration registers
   logic [DB-1:0] width_ff, height_ff, wc_ff, hc_ff;
   logic [DB-1:0] width_in, height_in, wc_in, hc_in;
   logic [12:0]   wv13;
   logic [DB-1:0] w_clamp, h_clamp;
   logic          csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign wv13   = {2'b00, pwdata[DB-1:0]};

   always_comb begin
      w_clamp = pwdata[DB-1:0];
      if (wv13 < 13'd2) begin
         w_clamp = DB'(2);
      end else if (wv13 > W_HI) begin
         w_clamp = W_HI[DB-1:0];
      end
      h_clamp = pwdata[DB-1:0];
      if (wv13 < 13'd2) begin
         h_clamp = DB'(2);
      end else if (wv13 > H_HI) begin
         h_clamp = H_HI[DB-1:0];
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      wc_in     = wc_ff;
      hc_in     = hc_ff;
      if (csr_wr) begin
         case (bb3_pkg::reg_idx_type'(paddr[2]))
            bb3_pkg::REG_FRAME_WIDTH: begin
               width_in = pwdata[DB-1:0];
               wc_in    = w_clamp;
            end
            bb3_pkg::REG_FRAME_HEIGHT: begin
               height_in = pwdata[DB-1:0];
               hc_in     = h_clamp;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (bb3_pkg::reg_idx_type'(paddr[2]))
         bb3_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, width_ff};
         bb3_pkg::REG_FRAME_HEIGHT: prdata = {21'd0, height_ff};
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DB'(bb3_pkg::FRAME_WIDTH_RST);
         height_ff <= DB'(bb3_pkg::FRAME_HEIGHT_RST);
         wc_ff     <= W_RST;
         hc_ff     <= H_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         wc_ff     <= wc_in;
         hc_ff     <= hc_in;
      end
   end

   // position counters and request decode
   logic [AW-1:0] col_ff, col_in;
   logic [DB-1:0] row_ff, row_in;
   logic [11:0]   r12, h12;
   logic [12:0]   col_next;
   logic          req_fire, lb_busy;
   bb3_pkg::ctl_type ctl0;
   logic [PB-1:0] pix0;

   assign r12      = {1'b0, row_ff};
   assign h12      = {1'b0, hc_ff};
   assign col_next = 13'(col_ff) + 13'd1;

   always_comb begin
      ctl0.c0     = (col_ff == '0);
      ctl0.last   = ctl0.c0 && (r12 >= h12 + 12'd1);
      ctl0.emit   = (ctl0.c0 && (r12 >= 12'd2)) ||
                    (!ctl0.c0 && (r12 >= 12'd1) && (r12 <= h12));
      ctl0.up_en  = (r12 >= 12'd2) && (r12 < h12 + 12'd2);
      ctl0.mid_en = (r12 >= 12'd1) && (r12 < h12 + 12'd1);
      pix0        = (!req_if.drain && (r12 < h12)) ? req_if.pixel_word[31:8] : '0;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (ctl0.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= 13'(wc_ff)) begin
            col_in = '0;
            row_in = row_ff + DB'(1);
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store data, window column sums
   logic             s1_v_ff, s1_v_in;
   bb3_pkg::ctl_type s1_ctl_ff;
   logic [PB-1:0]    s1_pix_ff;
   logic [AW-1:0]    s1_idx_ff;
   logic [PB-1:0]    rd_up, rd_mid, up_g, mid_g;
   logic             s1_go, s2_free, out_free;
   logic [2:0][CB-1:0] a_ff, b_ff, a_in, b_in, newcs;
   logic [2:0][SB-1:0] sum1;

   bb3_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_up   (rd_up),
      .rd_mid  (rd_mid),
      .wr_en   (s1_go && !s1_ctl_ff.last),
      .wr_addr (s1_idx_ff),
      .wr_up   (mid_g),
      .wr_mid  (s1_pix_ff),
      .busy    (lb_busy)
   );

   assign s1_go        = s1_v_ff && (!s1_ctl_ff.emit || s2_free);
   assign req_if.ready = !lb_busy && (!s1_v_ff || s1_go);
   assign req_fire     = req_if.valid && req_if.ready;
   assign up_g         = s1_ctl_ff.up_en  ? rd_up  : '0;
   assign mid_g        = s1_ctl_ff.mid_en ? rd_mid : '0;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         newcs[ch] = CB'(up_g[ch*8 +: 8]) + CB'(mid_g[ch*8 +: 8]) +
                     CB'(s1_pix_ff[ch*8 +: 8]);
         sum1[ch]  = SB'(a_ff[ch]) + SB'(b_ff[ch]) +
                     (s1_ctl_ff.c0 ? SB'(0) : SB'(newcs[ch]));
      end
      a_in = a_ff;
      b_in = b_ff;
      if (s1_go) begin
         if (s1_ctl_ff.last) begin
            a_in = '0;
            b_in = '0;
         end else if (s1_ctl_ff.c0) begin
            a_in = '0;
            b_in = newcs;
         end else begin
            a_in = b_ff;
            b_in = newcs;
         end
      end
      s1_v_in = req_fire ? 1'b1 : (s1_go ? 1'b0 : s1_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         a_ff    <= '0;
         b_ff    <= '0;
      end else begin
         s1_v_ff <= s1_v_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctl_ff <= ctl0;
         s1_pix_ff <= pix0;
         s1_idx_ff <= col_ff;
      end
   end

   // stage 2: window sums; output register: divide by 9
   logic               s2_v_ff, s2_v_in, s2_last_ff, s2_load, s2_move;
   logic [2:0][SB-1:0] s2_sum_ff;
   logic               out_v_ff, out_v_in, out_last_ff;
   logic [31:0]        out_word_ff;

   assign out_free = !out_v_ff || rsp_if.ready;
   assign s2_free  = !s2_v_ff || out_free;
   assign s2_load  = s1_go && s1_ctl_ff.emit;
   assign s2_move  = s2_v_ff && out_free;
   assign s2_v_in  = s2_load ? 1'b1 : (s2_move ? 1'b0 : s2_v_ff);
   assign out_v_in = s2_move ? 1'b1 : (rsp_if.ready ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_sum_ff  <= sum1;
         s2_last_ff <= s1_ctl_ff.last;
      end
      if (s2_move) begin
         out_word_ff <= {bb3_pkg::div9(s2_sum_ff[2]), bb3_pkg::div9(s2_sum_ff[1]),
                         bb3_pkg::div9(s2_sum_ff[0]), bb3_pkg::ALPHA};
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_if.valid         = out_v_ff;
   assign rsp_if.blurred_word  = out_word_ff;
   assign rsp_if.last_of_frame = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      lb_busy |-> !req_if.ready)
      else $error("request taken during line store clear");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && ctl0.last |=> (col_ff == '0) && (row_ff == '0))
      else $error("frame end did not restart position");

   assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_ctl_ff.last |-> s1_ctl_ff.c0 && s1_ctl_ff.emit)
      else $error("frame end request without result");

   assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !out_free |=> s2_v_ff && $stable(s2_sum_ff))
      else $error("sum stage lost a result under stall");

endmodule

`default_nettype wire

### rtl/bb3_line_store.sv
`default_nettype none

module bb3_line_store #(
   parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output logic      [bb3_pkg::PIX_BITS-1:0] rd_up,
   output logic      [bb3_pkg::PIX_BITS-1:0] rd_mid,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  wire logic [bb3_pkg::PIX_BITS-1:0] wr_up,
   input  wire logic [bb3_pkg::PIX_BITS-1:0] wr_mid,
   output logic                              busy
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [bb3_pkg::PIX_BITS-1:0] up_mem  [MAX_WIDTH];
   logic [bb3_pkg::PIX_BITS-1:0] mid_mem [MAX_WIDTH];

   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         up_mem[clr_addr_ff]  <= '0;
         mid_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         up_mem[wr_addr]  <= wr_up;
         mid_mem[wr_addr] <= wr_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_up  <= up_mem[rd_addr];
         rd_mid <= mid_mem[rd_addr];
      end
   end

   assign busy = clr_ff;

   assert property (@(posedge clock) disable iff (reset)
      clr_ff && !$past(reset) |-> $past(clr_ff))
      else $error("line store clear restarted without reset");

   assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !rd_en && !wr_en)
      else $error("line store accessed during clear");

   assert property (@(posedge clock) disable iff (reset)
      $fell(clr_ff) |-> $past(clr_addr_ff) == AW'(MAX_WIDTH - 1))
      else $error("line store clear ended early");

endmodule

`default_nettype wire

### dv/box_blur_3x3_rgb_tb.sv
`timescale 1ns / 100ps

module box_blur_3x3_rgb_tb;

   localparam int MAX_W          = bb3_pkg::MAX_WIDTH_DEF;
   localparam int MAX_H          = bb3_pkg::MAX_HEIGHT_DEF;
   localparam int RESULT_LATENCY = 3;
   localparam int CYCLE_LIMIT    = 100000;

   typedef struct packed {
      logic [31:0] pixel;
      logic        last;
   } blurred_px_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bb3_req_if req_if ();
   bb3_rsp_if rsp_if ();

   box_blur_3x3_rgb DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // blur predictor state
   logic [10:0] cfg_width  = 11'd800;
   logic [10:0] cfg_height = 11'd600;
   logic [23:0] upper_line [MAX_W] = '{default: '0};
   logic [23:0] middle_line [MAX_W] = '{default: '0};
   logic [23:0] window_px [9] = '{default: '0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   blurred_px_type expected_blur [$];
   blurred_px_type due_px;

   int fail_count     = 0;
   int request_count  = 0;
   int checked_count  = 0;
   int frame_count    = 0;
   int cycle_count    = 0;
   int sender_idle_pct = 0;
   int stall_pct      = 0;
   int hold_off_len   = 0;
   int hold_off_done  = 0;

   function automatic int unsigned effective_dim(input logic [10:0] v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [31:0] window_average(input int first_col);
      int unsigned sum_r, sum_g, sum_b;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = first_col; j < 3; j++) begin
            sum_r += window_px[i*3+j][23:16];
            sum_g += window_px[i*3+j][15:8];
            sum_b += window_px[i*3+j][7:0];
         end
      end
      return {8'(sum_r / 9), 8'(sum_g / 9), 8'(sum_b / 9), bb3_pkg::ALPHA};
   endfunction

   function automatic void predict_blur(input logic [31:0] word, input logic drain_bit);
      int unsigned w, h, r, c, idx;
      logic [23:0] pix, up_px, mid_px;
      logic        ends_frame;
      w   = effective_dim(cfg_width, MAX_W);
      h   = effective_dim(cfg_height, MAX_H);
      r   = row_pos;
      c   = col_pos;
      idx = c % MAX_W;
      if (c == 0) begin
         if (r >= 2) begin
            ends_frame = (r >= h + 1);
            expected_blur.push_back(blurred_px_type'{pixel: window_average(1),
                                                      last: ends_frame});
            if (ends_frame) begin
               foreach (window_px[i]) window_px[i] = '0;
               row_pos = 0;
               col_pos = 0;
               return;
            end
         end
         foreach (window_px[i]) window_px[i] = '0;
      end
      pix    = (!drain_bit && r < h) ? word[31:8] : '0;
      up_px  = (r >= 2 && r - 2 < h) ? upper_line[idx] : '0;
      mid_px = (r >= 1 && r - 1 < h) ? middle_line[idx] : '0;
      upper_line[idx]  = mid_px;
      middle_line[idx] = pix;
      for (int i = 0; i < 3; i++) begin
         window_px[i*3]   = window_px[i*3+1];
         window_px[i*3+1] = window_px[i*3+2];
      end
      window_px[2] = up_px;
      window_px[5] = mid_px;
      window_px[8] = pix;
      if (c >= 1 && r >= 1 && r <= h)
         expected_blur.push_back(blurred_px_type'{pixel: window_average(0), last: 1'b0});
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1) & 32'h7FF;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic void note_failure(input string msg);
      if (fail_count < 10) $display("ERROR: %s", msg);
      fail_count++;
   endfunction

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(7))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0000_0000;
         2: return {24'hFF_FFFF, 8'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_blur.size() == 0) begin
            note_failure($sformatf("unexpected result %h last %b",
                                   rsp_if.blurred_word, rsp_if.last_of_frame));
         end else begin
            due_px = expected_blur.pop_front();
            checked_count++;
            if (due_px.last) frame_count++;
            if (rsp_if.blurred_word !== due_px.pixel || rsp_if.last_of_frame !== due_px.last)
               note_failure($sformatf("result %0d: expected %h last %b, got %h last %b",
                                      checked_count, due_px.pixel, due_px.last,
                                      rsp_if.blurred_word, rsp_if.last_of_frame));
         end
      end
   end

   // result side stalls and hold-off
   always @(posedge clock) begin
      if (hold_off_done < hold_off_len) begin
         rsp_if.ready  <= 1'b0;
         hold_off_done <= hold_off_done + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_blur.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] word, input logic drain_bit);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.pixel_word <= word;
      req_if.drain      <= drain_bit;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_blur(word, drain_bit);
      request_count++;
   endtask

   task automatic send_random_item(input int drain_pct);
      send_request(random_pixel(), $urandom_range(99) < drain_pct);
   endtask

   // flush until the frame position wraps back to the top-left corner
   task automatic finish_frame(input int pixel_pct);
      while (row_pos != 0 || col_pos != 0) send_random_item(100 - pixel_pct);
   endtask

   task automatic send_frame(input int drain_pct, input int junk_pct);
      repeat (effective_dim(cfg_width, MAX_W) * effective_dim(cfg_height, MAX_H))
         send_random_item(drain_pct);
      finish_frame(junk_pct);
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (expected_blur.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input bb3_pkg::reg_idx_type which, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (which == bb3_pkg::REG_FRAME_WIDTH) cfg_width = value[10:0];
      else cfg_height = value[10:0];
      @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [31:0] width, input logic [31:0] height);
      wait_results_drained();
      write_csr(bb3_pkg::REG_FRAME_WIDTH, width);
      write_csr(bb3_pkg::REG_FRAME_HEIGHT, height);
   endtask

   task automatic test_corner_pixels();
      logic [31:0] corner [4] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FF00, 32'h0000_00FF};
      set_frame_size(2, 2);
      foreach (corner[i]) send_request(corner[i], 1'b0);
      repeat (3) send_request(32'h0, 1'b1);
   endtask

   task automatic test_clamped_dims_and_drains();
      // width masks to zero, height below range: both clamp to 2
      set_frame_size(32'h0000_0800, 32'h0000_0001);
      send_request($urandom, 1'b0);
      send_request(32'hFFFF_FFFF, 1'b1);
      send_request($urandom, 1'b0);
      send_request(32'hFFFF_FFFF, 1'b0);
      // pixels past the last line count as zero
      send_request(32'hFFFF_FFFF, 1'b0);
      send_request(32'h0, 1'b1);
      send_request(32'h1234_5678, 1'b0);
   endtask

   task automatic test_midframe_resize();
      set_frame_size(4, 3);
      repeat (7) send_request(random_pixel(), 1'b0);
      // column 3 is past the new width and wraps
      set_frame_size(3, 2);
      finish_frame(0);
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      stall_pct       = 0;
      set_frame_size(16, 8);
      hold_off_len = 300;
      send_frame(0, 0);
      wait_results_drained();
   endtask

   task automatic run_random_frames(input int send_pct, input int recv_pct, input int goal);
      int first;
      first           = request_count;
      sender_idle_pct = send_pct;
      stall_pct       = recv_pct;
      while (request_count - first < goal) begin
         set_frame_size(($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12),
                        $urandom_range(0, 6));
         repeat ($urandom_range(1, 3)) send_frame(5, 15);
         if ($urandom_range(5) == 0) begin
            // broken frame: resize partway through
            repeat ($urandom_range(1, 30)) send_random_item(10);
            set_frame_size($urandom_range(0, 12), $urandom_range(0, 6));
            finish_frame(15);
         end
      end
      wait_results_drained();
   endtask

   task automatic test_random_frames();
      run_random_frames(0, 0, 80);
      run_random_frames(78, 0, 80);
      run_random_frames(0, 78, 80);
      run_random_frames(13, 13, 80);
   endtask

   task automatic test_oversized_dims();
      sender_idle_pct = 0;
      stall_pct       = 0;
      // dimensions clamp to the maximum, then the frame is cut short by a resize
      set_frame_size(32'hFFFF_FFFF, 2);
      repeat (40) send_random_item(2);
      set_frame_size(4, 2);
      finish_frame(5);
      set_frame_size(2, 32'hFFFF_FFFF);
      repeat (12) send_random_item(2);
      set_frame_size(2, 2);
      finish_frame(5);
      wait_results_drained();
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.pixel_word = '0;
      req_if.drain      = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // line store clearing pass
      do @(posedge clock); while (req_if.ready !== 1'b1);

      test_corner_pixels();
      test_clamped_dims_and_drains();
      test_midframe_resize();
      test_output_backpressure();
      test_random_frames();
      test_oversized_dims();

      wait_results_drained();
      repeat (RESULT_LATENCY * 4) @(posedge clock);
      $display("%0d requests over %0d frames, %0d blurred pixels checked",
               request_count, frame_count, checked_count);
      $display("sizes from 2x2 up to clamped 1024 settings, resized frames, drains, stalls");
      if (fail_count == 0 && expected_blur.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d failures", fail_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
